@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("check failed");
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("check failed");
`endif

@@ rtl/core/imrg_pkg.sv @@
`timescale 1ns / 1ps
// package for interval_merge: sizes and command/status structs
// no dependencies
package imrg_pkg;
	localparam int MaxIntervals = 64;
	localparam int ValueBits = 32;
	localparam int IdxBits = $clog2(MaxIntervals);
	localparam int CntBits = $clog2(MaxIntervals + 1);
	localparam int TdataInBits = ((2 * ValueBits + 7) / 8) * 8;
	localparam int TdataOutBits = ((2 * ValueBits + 7) / 8) * 8;

	typedef logic signed [ValueBits-1:0] val_t;

	typedef struct packed {
		logic load;      // capture input transfer, pointer to zero
		logic step_up;   // pointer forward
		logic wr_max;    // keep the larger right end at pointer
		logic wr_new;    // write new interval at pointer, count up
		logic set_ovf;   // interval dropped, table full
		logic sh_start;  // note insert position, pointer to count
		logic rd_below;  // read entry below pointer
		logic wr_shift;  // move entry read up to pointer, pointer back
		logic sw_init;   // pointer to zero for the sweep
		logic cur_load;  // current group from entry read
		logic cur_merge; // widen current group by entry read
		logic clear;     // empty table after batch
	} imrg_cmd_t;

	typedef struct packed {
		logic last_item;
		logic at_end;    // pointer at entry count
		logic full;
		logic key_eq;    // entry read has the same left end
		logic key_lt;    // entry read has a smaller left end
		logic sh_last;   // this shift write lands just above insert position
		logic sw_first;
		logic sw_merge;  // entry read touches or overlaps current group
	} imrg_sts_t;
endpackage

@@ rtl/core/imrg_datapath.sv @@
`timescale 1ns / 1ps
// interval_merge datapath: sorted table memory, insertion shifter, merge sweep
// depends on imrg_pkg
module imrg_datapath import imrg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  imrg_cmd_t             cmd,
	input  val_t                  in_a,
	input  val_t                  in_b,
	input  logic                  in_last,
	output imrg_sts_t             sts,
	output val_t                  res_lo,
	output val_t                  res_hi,
	output logic                  res_ovf
);
	val_t s_mem [MaxIntervals];
	val_t e_mem [MaxIntervals];
	val_t lo_q, hi_q, rd_s_q, rd_e_q, cur_lo_q, cur_hi_q;
	logic last_q, ovf_q;
	logic [CntBits-1:0] cnt_q, ptr_q, pos_q, ptr_dn;
	logic [IdxBits-1:0] ra, wa;
	logic we;
	val_t ws, wend;

	assign ptr_dn = ptr_q - 1'b1;
	assign wa = ptr_q[IdxBits-1:0];

	always_comb begin
		ra = ptr_q[IdxBits-1:0];
		if (cmd.rd_below)
			ra = ptr_dn[IdxBits-1:0];
	end

	always_comb begin
		we = cmd.wr_max || cmd.wr_new || cmd.wr_shift;
		ws = lo_q;
		wend = hi_q;
		if (cmd.wr_shift) begin
			ws = rd_s_q;
			wend = rd_e_q;
		end else if (cmd.wr_max && rd_e_q > hi_q) begin
			wend = rd_e_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			s_mem[wa] <= ws;
			e_mem[wa] <= wend;
		end
		rd_s_q <= s_mem[ra];
		rd_e_q <= e_mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			ptr_q <= '0;
			pos_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (cmd.load)
				last_q <= in_last;
			if (cmd.load || cmd.sw_init)
				ptr_q <= '0;
			else if (cmd.step_up)
				ptr_q <= ptr_q + 1'b1;
			else if (cmd.sh_start)
				ptr_q <= cnt_q;
			else if (cmd.wr_shift)
				ptr_q <= ptr_dn;
			if (cmd.sh_start)
				pos_q <= ptr_q;
			if (cmd.clear)
				cnt_q <= '0;
			else if (cmd.wr_new)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.clear)
				ovf_q <= 1'b0;
			else if (cmd.set_ovf)
				ovf_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q <= (in_b < in_a) ? in_b : in_a;
			hi_q <= (in_b < in_a) ? in_a : in_b;
		end
		if (cmd.cur_load) begin
			cur_lo_q <= rd_s_q;
			cur_hi_q <= rd_e_q;
		end else if (cmd.cur_merge && rd_e_q > cur_hi_q) begin
			cur_hi_q <= rd_e_q;
		end
	end

	always_comb begin
		sts.last_item = last_q;
		sts.at_end = ptr_q == cnt_q;
		sts.full = cnt_q == CntBits'(MaxIntervals);
		sts.key_eq = rd_s_q == lo_q;
		sts.key_lt = rd_s_q < lo_q;
		sts.sh_last = ptr_dn == pos_q;
		sts.sw_first = ptr_q == '0;
		sts.sw_merge = rd_s_q <= cur_hi_q;
	end

	assign res_lo = cur_lo_q;
	assign res_hi = cur_hi_q;
	assign res_ovf = ovf_q;
endmodule

@@ rtl/core/imrg_ctrl.sv @@
`timescale 1ns / 1ps
// interval_merge controller: sequences load, insert, sweep and emit
// depends on imrg_pkg
module imrg_ctrl import imrg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      out_last,
	input  imrg_sts_t sts,
	output imrg_cmd_t cmd
);
	typedef enum logic [3:0] {
		Idle, SrchRd, SrchCmp, ShRd, ShWr, InsNew, SwRd, SwCmp, Emit, EmitFin
	} st_t;
	st_t st_q;
	logic ins_fin;

	assign in_ready = st_q == Idle;
	assign out_valid = st_q == Emit || st_q == EmitFin;
	assign out_last = st_q == EmitFin;

	always_comb begin
		cmd = '0;
		ins_fin = 1'b0;
		case (st_q)
			Idle: cmd.load = in_valid;
			SrchCmp: begin
				if (!sts.at_end && sts.key_lt) begin
					cmd.step_up = 1'b1;
				end else if (!sts.at_end && sts.key_eq) begin
					cmd.wr_max = 1'b1;
					ins_fin = 1'b1;
				end else if (sts.full) begin
					cmd.set_ovf = 1'b1;
					ins_fin = 1'b1;
				end else if (sts.at_end) begin
					cmd.wr_new = 1'b1;
					ins_fin = 1'b1;
				end else begin
					cmd.sh_start = 1'b1;
				end
			end
			ShRd: cmd.rd_below = 1'b1;
			ShWr: cmd.wr_shift = 1'b1;
			InsNew: begin
				cmd.wr_new = 1'b1;
				ins_fin = 1'b1;
			end
			SwCmp: begin
				if (sts.sw_first) begin
					cmd.cur_load = 1'b1;
					cmd.step_up = 1'b1;
				end else if (sts.sw_merge) begin
					cmd.cur_merge = 1'b1;
					cmd.step_up = 1'b1;
				end
			end
			Emit: begin
				if (out_ready) begin
					cmd.cur_load = 1'b1;
					cmd.step_up = 1'b1;
				end
			end
			EmitFin: cmd.clear = out_ready;
			default: cmd = '0;
		endcase
		cmd.sw_init = ins_fin && sts.last_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= Idle;
		end else begin
			case (st_q)
				Idle: if (in_valid) st_q <= SrchRd;
				SrchRd: st_q <= SrchCmp;
				SrchCmp: begin
					if (ins_fin)
						st_q <= sts.last_item ? SwRd : Idle;
					else if (cmd.sh_start)
						st_q <= ShRd;
					else
						st_q <= SrchRd;
				end
				ShRd: st_q <= ShWr;
				ShWr: st_q <= sts.sh_last ? InsNew : ShRd;
				InsNew: st_q <= sts.last_item ? SwRd : Idle;
				SwRd: st_q <= sts.at_end ? EmitFin : SwCmp;
				SwCmp: st_q <= (sts.sw_first || sts.sw_merge) ? SwRd : Emit;
				Emit: if (out_ready) st_q <= SwRd;
				EmitFin: if (out_ready) st_q <= Idle;
				default: st_q <= Idle;
			endcase
		end
	end
endmodule

@@ rtl/core/interval_merge.sv @@
`timescale 1ns / 1ps
// interval_merge top level: sorted interval table with merge on batch end
// depends on imrg_pkg, imrg_ctrl, imrg_datapath, assert_macros.svh
//  channel | dir | contents
//  s_axis  | in  | tdata: range_start, range_end; tlast: batch_end
//  m_axis  | out | tdata: merged_start, merged_end; tuser: table_overflow; tlast: final_result
// an item is taken in one transfer, then compared with each stored left end below its own
// inserting below stored entries moves each entry up with a read and a write, then writes it
// a batch end then sweeps the entries with a read and a compare each, emitting each merged result,
// the last with tlast, each result held for as long as m_axis_tready stays low
// the table memory has one write and one read port with registered read data
// reset clears the entry count and overflow flag, the table itself is not cleared
`include "assert_macros.svh"
module interval_merge import imrg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [TdataInBits-1:0]  s_axis_tdata,  // range_start, range_end
	input  logic                    s_axis_tlast,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [TdataOutBits-1:0] m_axis_tdata,  // merged_start, merged_end
	output logic                    m_axis_tuser,  // table_overflow
	output logic                    m_axis_tlast
);
	imrg_cmd_t cmd;
	imrg_sts_t sts;
	val_t lo, hi;

	imrg_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_last(m_axis_tlast),
		.sts, .cmd
	);

	imrg_datapath u_dp (
		.clk, .arst_n, .cmd,
		.in_a(s_axis_tdata[ValueBits-1:0]),
		.in_b(s_axis_tdata[2*ValueBits-1:ValueBits]),
		.in_last(s_axis_tlast),
		.sts, .res_lo(lo), .res_hi(hi), .res_ovf(m_axis_tuser)
	);

	assign m_axis_tdata = TdataOutBits'({hi, lo});

	`CHK_IMPL(a_no_in_while_out, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	`CHK_NEXT(a_last_returns_idle, clk, arst_n,
		m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
	`CHK_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
endmodule
